// File: rtl/core/wcmmr_pkg.sv
// ----------------------------------------------------------------------------
// wcmmr_pkg
// Shared types and constants of the waveform column min/max/RMS summariser.
// ----------------------------------------------------------------------------
package wcmmr_pkg;

    localparam int RESULT_LIMIT = 64;
    localparam int SUMSQ_W      = 55;

    localparam logic [1:0] REG_VIEW_LENGTH   = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // One closing request handed from the front end to the back end.
    typedef struct packed {
        logic [11:0]        column;
        logic [2:0]         channel;
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic [SUMSQ_W-1:0] sum_sq;
        logic [24:0]        frames;
        logic [6:0]         copies;
        logic               truncated;
    } close_req_t;

endpackage

// File: rtl/core/wcmmr_front.sv
// ----------------------------------------------------------------------------
// wcmmr_front
// Accumulate samples per channel, track column boundaries and raise a
// closing request when a column's last frame arrives.
// ----------------------------------------------------------------------------
module wcmmr_front #(
    parameter int MAX_CHANNELS    = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   restart,
    input  logic [24:0]            n_eff,
    input  logic [12:0]            w_eff,
    input  logic [3:0]             nc_eff,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [15:0]     sample,
    output logic                   req_valid,
    input  logic                   req_stall,
    output wcmmr_pkg::close_req_t  req
);
    import wcmmr_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_WRAP  = 4'b1000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic signed [15:0] min_reg [MAX_CHANNELS];
    logic signed [15:0] max_reg [MAX_CHANNELS];
    logic [SUMSQ_W-1:0] sq_reg  [MAX_CHANNELS];
    logic [24:0]        frame_reg;
    logic [3:0]         chan_reg;
    logic [12:0]        col_reg;
    logic [12:0]        scan_reg;
    logic [24:0]        start_reg;
    logic [6:0]         total_reg;
    logic               trunc_reg;
    // boundary tracking: end of column scan_reg = q_reg (+ remainder rem_reg)
    logic [24:0]        q_reg;
    logic [12:0]        rem_reg;
    logic [24:0]        prev_q_reg;
    logic [31:0]        sq_prod_reg;
    logic [CH_W-1:0]    cidx;
    logic [25:0]        e_raw;

    // N = qn*W + rn, worked out bit-serially after each restart
    logic [24:0] qn_reg;
    logic [12:0] rn_reg;
    logic [25:0] dv_rem_reg;
    logic [4:0]  dv_cnt_reg;
    logic        dv_busy_reg;
    logic [25:0] dv_trial;

    // Quotient state for the open column: floor(col*N/W) and floor((col+1)*N/W),
    // kept in step as col advances (updated when the frame commits).
    logic [24:0] col_prev_reg, col_q_reg;
    logic [12:0] col_r_reg;

    assign cidx = chan_reg[CH_W-1:0];
    assign in_stall = (state_reg != ST_IDLE) || dv_busy_reg;

    // column end for scan_reg from running quotient
    always_comb
    begin
        e_raw = {1'b0, q_reg};
        if (q_reg <= prev_q_reg)
            e_raw = {1'b0, prev_q_reg} + 26'd1;
        if (e_raw > {1'b0, n_eff})
            e_raw = {1'b0, n_eff};
    end

    // next quotient/remainder step: (k+1)*N/W advanced by N/W with carry
    logic [37:0] n_by_w_sum;
    logic [24:0] q_step;
    logic [12:0] r_step;
    always_comb
    begin
        n_by_w_sum = {13'd0, n_eff} + 38'(0);
        q_step = q_reg;
        r_step = rem_reg;
        // add N to the numerator; fold whole multiples of W one at a time is
        // too slow, so keep N split as qn*W + rn (registered below)
        q_step = q_reg + qn_reg;
        if ({1'b0, rem_reg} + {1'b0, rn_reg} >= {1'b0, w_eff})
        begin
            q_step = q_reg + qn_reg + 25'd1;
            r_step = 13'(({1'b0, rem_reg} + {1'b0, rn_reg}) - {1'b0, w_eff});
        end
        else
            r_step = rem_reg + rn_reg;
        if (n_by_w_sum == 38'd0)
            r_step = rem_reg;
    end

    assign dv_trial = {dv_rem_reg[24:0], n_eff[dv_cnt_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= 5'd24;
            dv_rem_reg  <= '0;
            qn_reg      <= '0;
            rn_reg      <= '0;
        end
        else if (restart)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= 5'd24;
            dv_rem_reg  <= '0;
            qn_reg      <= '0;
        end
        else if (dv_busy_reg)
        begin
            if (dv_trial >= {13'd0, w_eff})
            begin
                dv_rem_reg <= dv_trial - {13'd0, w_eff};
                qn_reg     <= {qn_reg[23:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_trial;
                qn_reg     <= {qn_reg[23:0], 1'b0};
            end
            if (dv_cnt_reg == 5'd0)
            begin
                dv_busy_reg <= 1'b0;
                rn_reg <= (dv_trial >= {13'd0, w_eff}) ?
                          13'(dv_trial - {13'd0, w_eff}) : 13'(dv_trial);
            end
            else
                dv_cnt_reg <= dv_cnt_reg - 5'd1;
        end
    end

    logic first_scan_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && !dv_busy_reg && !restart) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (first_scan_reg)
                    state_next = ST_SCAN;
                else if ({12'd0, scan_reg} < {12'd0, w_eff} &&
                    e_raw == {1'b0, frame_reg} + 26'd1)
                    state_next = ST_SCAN;
                else if (total_reg != 7'd0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_WRAP;
            end
            ST_EMIT: if (!req_stall) state_next = ST_WRAP;
            ST_WRAP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign req_valid = (state_reg == ST_EMIT);
    always_comb
    begin
        req.column    = col_reg[11:0];
        req.channel   = chan_reg[2:0];
        req.minimum   = min_reg[cidx];
        req.maximum   = max_reg[cidx];
        req.sum_sq    = sq_reg[cidx];
        req.frames    = (start_reg <= frame_reg) ? frame_reg - start_reg + 25'd1 : 25'd1;
        req.copies    = total_reg;
        req.truncated = trunc_reg;
    end

    logic last_chan;
    assign last_chan = ({1'b0, chan_reg} + 5'd1 >= {1'b0, nc_eff});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            frame_reg <= '0;
            chan_reg  <= '0;
            col_reg   <= '0;
            scan_reg  <= '0;
            start_reg <= '0;
            total_reg <= '0;
            trunc_reg <= 1'b0;
            q_reg     <= '0;
            rem_reg   <= '0;
            prev_q_reg <= '0;
            first_scan_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                min_reg[i] <= 16'sh7FFF;
                max_reg[i] <= -16'sh8000;
                sq_reg[i]  <= '0;
            end
        end
        else if (restart)
        begin
            state_reg <= ST_IDLE;
            frame_reg <= '0;
            chan_reg  <= '0;
            col_reg   <= '0;
            start_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                min_reg[i] <= 16'sh7FFF;
                max_reg[i] <= -16'sh8000;
                sq_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !dv_busy_reg)
                    begin
                        sq_prod_reg <= 32'($signed(sample) * $signed(sample));
                        if (sample < min_reg[cidx]) min_reg[cidx] <= sample;
                        if (sample > max_reg[cidx]) max_reg[cidx] <= sample;
                        scan_reg  <= col_reg;
                        total_reg <= '0;
                        trunc_reg <= 1'b0;
                        first_scan_reg <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (first_scan_reg)
                    begin
                        first_scan_reg <= 1'b0;
                        sq_reg[cidx] <= sq_reg[cidx] + {23'd0, sq_prod_reg};
                        // position quotient at start and end of column col_reg
                        q_reg      <= col_q_reg;
                        rem_reg    <= col_r_reg;
                        prev_q_reg <= col_prev_reg;
                    end
                    else if ({12'd0, scan_reg} < {12'd0, w_eff} &&
                             e_raw == {1'b0, frame_reg} + 26'd1)
                    begin
                        scan_reg   <= scan_reg + 13'd1;
                        prev_q_reg <= q_reg;
                        q_reg      <= q_step;
                        rem_reg    <= r_step;
                        if (total_reg == 7'(RESULT_LIMIT))
                            trunc_reg <= 1'b1;
                        else
                            total_reg <= total_reg + 7'd1;
                    end
                end
                ST_EMIT: ;
                ST_WRAP:
                begin
                    if (total_reg != 7'd0)
                    begin
                        min_reg[cidx] <= 16'sh7FFF;
                        max_reg[cidx] <= -16'sh8000;
                        sq_reg[cidx]  <= '0;
                    end
                    if (last_chan)
                    begin
                        chan_reg <= '0;
                        if (scan_reg != col_reg)
                            start_reg <= frame_reg + 25'd1;
                        col_reg <= scan_reg;
                        if (frame_reg + 25'd1 >= n_eff)
                        begin
                            frame_reg <= '0;
                            col_reg   <= '0;
                            start_reg <= '0;
                            for (int i = 0; i < MAX_CHANNELS; i++)
                            begin
                                min_reg[i] <= 16'sh7FFF;
                                max_reg[i] <= -16'sh8000;
                                sq_reg[i]  <= '0;
                            end
                        end
                        else
                            frame_reg <= frame_reg + 25'd1;
                    end
                    else
                        chan_reg <= chan_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_prev_reg <= '0;
            col_q_reg    <= '0;
            col_r_reg    <= '0;
        end
        else if (restart || (dv_busy_reg && dv_cnt_reg == 5'd0))
        begin
            col_prev_reg <= '0;
            col_q_reg    <= qn_reg;
            col_r_reg    <= rn_reg;
            if (dv_busy_reg)
            begin
                col_q_reg <= (dv_trial >= {13'd0, w_eff}) ?
                             {qn_reg[23:0], 1'b1} : {qn_reg[23:0], 1'b0};
                col_r_reg <= (dv_trial >= {13'd0, w_eff}) ?
                             13'(dv_trial - {13'd0, w_eff}) : 13'(dv_trial);
            end
        end
        else if (state_reg == ST_WRAP && last_chan)
        begin
            if (frame_reg + 25'd1 >= n_eff)
            begin
                col_prev_reg <= '0;
                col_q_reg    <= qn_reg;
                col_r_reg    <= rn_reg;
            end
            else
            begin
                col_prev_reg <= prev_q_reg;
                col_q_reg    <= q_reg;
                col_r_reg    <= rem_reg;
            end
        end
    end

endmodule

// File: rtl/core/wcmmr_back.sv
// ----------------------------------------------------------------------------
// wcmmr_back
// Divide the sum of squares by the frame count, take the integer square
// root and emit one result per closed column, at most 64 per request.
// ----------------------------------------------------------------------------
module wcmmr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  wcmmr_pkg::close_req_t  req,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [11:0]            column,
    output logic [2:0]             channel,
    output logic signed [15:0]     minimum,
    output logic signed [15:0]     maximum,
    output logic [15:0]            root_mean_square,
    output logic                   truncated,
    output logic                   last
);
    import wcmmr_pkg::*;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_DIV  = 4'b0010,
        BK_SQRT = 4'b0100,
        BK_OUT  = 4'b1000
    } bstate_t;

    bstate_t            state_reg;
    close_req_t         job_reg;
    logic [SUMSQ_W-1:0] quo_reg;
    logic [25:0]        drem_reg;
    logic [5:0]         cnt_reg;
    logic [SUMSQ_W-1:0] sx_reg;
    logic [31:0]        sres_reg;
    logic [6:0]         idx_reg;
    logic [25:0]        dtrial;
    logic [SUMSQ_W+1:0] sq_x;
    logic [SUMSQ_W+1:0] sq_try;

    assign req_stall = (state_reg != BK_IDLE);
    assign dtrial = {drem_reg[24:0], quo_reg[SUMSQ_W-1]};
    assign sq_x   = {2'b0, sx_reg};
    assign sq_try = {25'd0, sres_reg} + ({{(SUMSQ_W+1){1'b0}}, 1'b1} << {cnt_reg, 1'b0});

    assign out_valid        = (state_reg == BK_OUT);
    assign column           = 12'(job_reg.column + {5'd0, idx_reg});
    assign channel          = job_reg.channel;
    assign minimum          = job_reg.minimum;
    assign maximum          = job_reg.maximum;
    assign root_mean_square = sres_reg[15:0];
    assign truncated        = job_reg.truncated;
    assign last             = (idx_reg + 7'd1 == job_reg.copies);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                BK_IDLE:
                begin
                    if (req_valid)
                    begin
                        job_reg   <= req;
                        quo_reg   <= req.sum_sq;
                        drem_reg  <= '0;
                        cnt_reg   <= 6'(SUMSQ_W - 1);
                        state_reg <= BK_DIV;
                    end
                end
                // restoring division, one quotient bit a cycle
                BK_DIV:
                begin
                    if (dtrial >= {1'b0, job_reg.frames})
                    begin
                        drem_reg <= dtrial - {1'b0, job_reg.frames};
                        quo_reg  <= {quo_reg[SUMSQ_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dtrial;
                        quo_reg  <= {quo_reg[SUMSQ_W-2:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= BK_SQRT;
                        cnt_reg   <= 6'd27;
                        sres_reg  <= '0;
                        sx_reg    <= (dtrial >= {1'b0, job_reg.frames}) ?
                                     {quo_reg[SUMSQ_W-2:0], 1'b1} :
                                     {quo_reg[SUMSQ_W-2:0], 1'b0};
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                // digit-by-digit square root, one result bit a cycle
                BK_SQRT:
                begin
                    if (sq_x >= sq_try)
                    begin
                        sx_reg   <= SUMSQ_W'(sq_x - sq_try);
                        sres_reg <= 32'((sq_try[SUMSQ_W+1:0] >> 1) +
                                        ({{(SUMSQ_W+1){1'b0}}, 1'b1} << {cnt_reg, 1'b0}) -
                                        ({{(SUMSQ_W+1){1'b0}}, 1'b1} << ({cnt_reg, 1'b0} - 7'd1)));
                    end
                    else
                        sres_reg <= sres_reg >> 1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= BK_OUT;
                        idx_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                BK_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (last)
                            state_reg <= BK_IDLE;
                        else
                            idx_reg <= idx_reg + 7'd1;
                    end
                end
                default: state_reg <= BK_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/waveform_column_min_max_rms_top.sv
// ----------------------------------------------------------------------------
// waveform_column_min_max_rms_top
// Per-column min/max/RMS summary of an interleaved Q15 audio view.
// ----------------------------------------------------------------------------
// Samples enter one channel at a time. The front end scans every column that
// a sample ends, including those beyond the 64 that are emitted. Each closing
// request then runs a 55-step serial divider and a 28-step square root in the
// back end before its copies (at most 64) leave at one per cycle while the
// receiver does not stall. After reset or any write to a known register index
// a serial split of N by W runs before the first sample is taken.
module waveform_column_min_max_rms_top #(
    parameter int MAX_CHANNELS    = 8,
    parameter int MAX_COLUMNS     = 4096,
    parameter int MAX_VIEW_FRAMES = 16777216
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [24:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        column,
    output logic [2:0]         channel,
    output logic signed [15:0] minimum,
    output logic signed [15:0] maximum,
    output logic [15:0]        root_mean_square,
    output logic               truncated,
    output logic               last
);
    import wcmmr_pkg::*;

    logic [24:0] view_length_reg;
    logic [12:0] column_count_reg;
    logic [3:0]  channel_count_reg;
    logic        restart;
    logic [24:0] n_eff;
    logic [12:0] w_eff;
    logic [3:0]  nc_eff;
    logic        req_valid, req_stall;
    close_req_t  req;

    // hold registers; any write to a known index restarts the view
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_length_reg   <= 25'd1;
            column_count_reg  <= 13'd1;
            channel_count_reg <= 4'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VIEW_LENGTH:   view_length_reg   <= cfg_data;
                REG_COLUMN_COUNT:  column_count_reg  <= cfg_data[12:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic restart_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restart_reg <= 1'b0;
        else
            restart_reg <= cfg_write && (cfg_index == REG_VIEW_LENGTH ||
                                         cfg_index == REG_COLUMN_COUNT ||
                                         cfg_index == REG_CHANNEL_COUNT);
    end
    assign restart = restart_reg;

    // clamp registers into their legal ranges
    always_comb
    begin
        n_eff = view_length_reg;
        if (n_eff == 25'd0) n_eff = 25'd1;
        if ({7'd0, n_eff} > 32'(MAX_VIEW_FRAMES)) n_eff = 25'(MAX_VIEW_FRAMES);
        w_eff = column_count_reg;
        if (w_eff == 13'd0) w_eff = 13'd1;
        if ({19'd0, w_eff} > 32'(MAX_COLUMNS)) w_eff = 13'(MAX_COLUMNS);
        nc_eff = channel_count_reg;
        if (nc_eff == 4'd0) nc_eff = 4'd1;
        if ({28'd0, nc_eff} > 32'(MAX_CHANNELS)) nc_eff = 4'(MAX_CHANNELS);
    end

    logic in_stall_f;
    assign in_stall = in_stall_f || restart || cfg_write;

    wcmmr_front #(
        .MAX_CHANNELS   (MAX_CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .n_eff    (n_eff),
        .w_eff    (w_eff),
        .nc_eff   (nc_eff),
        .in_valid (in_valid && !cfg_write),
        .in_stall (in_stall_f),
        .sample   (sample),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req)
    );

    wcmmr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .column          (column),
        .channel         (channel),
        .minimum         (minimum),
        .maximum         (maximum),
        .root_mean_square(root_mean_square),
        .truncated       (truncated),
        .last            (last)
    );

`ifndef SYNTHESIS
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid)
        else $error("closing request dropped while stalled");
    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> root_mean_square <= 16'd32768)
        else $error("rms out of range");
    a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> minimum <= maximum)
        else $error("minimum above maximum");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the waveform column min/max/RMS summariser: drives
// interleaved Q15 samples under several view settings, predicts every column
// summary in-bench and compares each delivered summary field by field.
// ----------------------------------------------------------------------------
module testbench;

    import wcmmr_pkg::*;

    // Unused register slot: writes to it must be ignored by the block.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int VIEW_CAP    = 16777216;
    localparam int COLUMN_CAP  = 4096;
    localparam int CHANNEL_CAP = 8;
    localparam int IDLE_PCT    = 19;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 20000;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

    typedef struct packed {
        logic [11:0]        column;
        logic [2:0]         channel;
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic [15:0]        rms;
        logic               truncated;
        logic               last;
    } col_summary_t;

    // One row of the directed table: a register write or a sample, the latter
    // optionally with a hand-typed summary (only under the 1/1/1 setting).
    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         index;
        logic [24:0]        data;
        logic signed [15:0] smp;
        logic               typed;
        logic [15:0]        rms;
    } stim_row_t;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               typed;
        col_summary_t       want;
    } sample_req_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [24:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample;
    logic               out_valid;
    logic               out_stall;
    logic [11:0]        column;
    logic [2:0]         channel;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic [15:0]        root_mean_square;
    logic               truncated;
    logic               last;

    waveform_column_min_max_rms_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .column           (column),
        .channel          (channel),
        .minimum          (minimum),
        .maximum          (maximum),
        .root_mean_square (root_mean_square),
        .truncated        (truncated),
        .last             (last)
    );

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register copies plus per-channel accumulators.
    // ------------------------------------------------------------------------
    logic [24:0]        view_len_q;
    logic [12:0]        col_cnt_q;
    logic [3:0]         chan_cnt_q;
    logic signed [15:0] run_min [CHANNEL_CAP];
    logic signed [15:0] run_max [CHANNEL_CAP];
    logic [54:0]        run_sq  [CHANNEL_CAP];
    logic [23:0]        frame_pos;
    logic [2:0]         chan_pos;
    logic [11:0]        next_col;
    logic [23:0]        col_first_frame;

    col_summary_t summaries_due [$];
    sample_req_t  requests_open [$];

    int  errors;
    int  quiet_cycles;
    bit  idle_en;
    bit  hold_off;

    function automatic longint unsigned clamp_to(input longint unsigned v,
                                                 input longint unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // One past the last frame of column k; empty ranges widen to one frame.
    function automatic longint unsigned column_stop(input longint unsigned k,
                                                    input longint unsigned n,
                                                    input longint unsigned w);
        longint unsigned s;
        longint unsigned e;
        s = (k * n) / w;
        e = ((k + 1) * n) / w;
        if (e <= s)
            e = s + 1;
        if (e > n)
            e = n;
        return e;
    endfunction

    function automatic logic [15:0] floor_sqrt(input logic [54:0] x);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = x;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[15:0];
    endfunction

    task automatic restart_view();
        for (int c = 0; c < CHANNEL_CAP; c++)
        begin
            run_min[c] = 16'sh7FFF;
            run_max[c] = 16'sh8000;
            run_sq[c]  = '0;
        end
        frame_pos       = '0;
        chan_pos        = '0;
        next_col        = '0;
        col_first_frame = '0;
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [24:0] val);
        case (idx)
            REG_VIEW_LENGTH:   view_len_q = val;
            REG_COLUMN_COUNT:  col_cnt_q  = val[12:0];
            REG_CHANNEL_COUNT: chan_cnt_q = val[3:0];
            default:           return;
        endcase
        restart_view();
    endtask

    // Fold one accepted sample into the accumulators and queue the column
    // summaries it closes (or the hand-typed one, when the row carries it).
    task automatic summarise_sample(input logic signed [15:0] smp, input logic typed,
                                    input col_summary_t want);
        longint unsigned n;
        longint unsigned w;
        longint unsigned nc;
        longint unsigned f;
        longint unsigned k;
        longint unsigned total;
        longint unsigned shown;
        longint unsigned frames;
        logic [54:0]     sq;
        logic [15:0]     root;
        int              c;
        col_summary_t    s;
        n  = clamp_to(view_len_q, VIEW_CAP);
        w  = clamp_to(col_cnt_q, COLUMN_CAP);
        nc = clamp_to(chan_cnt_q, CHANNEL_CAP);
        c  = chan_pos;
        f  = frame_pos;
        k  = next_col;
        if (smp < run_min[c])
            run_min[c] = smp;
        if (smp > run_max[c])
            run_max[c] = smp;
        sq = 55'(longint'(smp) * longint'(smp));
        run_sq[c] = run_sq[c] + sq;
        total = 0;
        while (k < w && column_stop(k, n, w) == f + 1)
        begin
            total++;
            k++;
        end
        shown  = (total > RESULT_LIMIT) ? RESULT_LIMIT : total;
        frames = (col_first_frame <= f) ? f - col_first_frame + 1 : 1;
        root   = floor_sqrt(55'(run_sq[c] / frames));
        if (typed)
            summaries_due.push_back(want);
        else
            for (longint unsigned i = 0; i < shown; i++)
            begin
                s.column    = 12'(next_col + i);
                s.channel   = 3'(c);
                s.minimum   = run_min[c];
                s.maximum   = run_max[c];
                s.rms       = root;
                s.truncated = (total > RESULT_LIMIT);
                s.last      = (i + 1 == shown);
                summaries_due.push_back(s);
            end
        if (total > 0)
        begin
            run_min[c] = 16'sh7FFF;
            run_max[c] = 16'sh8000;
            run_sq[c]  = '0;
        end
        if (c + 1 >= nc)
        begin
            chan_pos = '0;
            next_col = 12'(k);
            if (total > 0)
                col_first_frame = 24'(f + 1);
            if (f + 1 >= n)
                restart_view();
            else
                frame_pos = 24'(f + 1);
        end
        else
            chan_pos = 3'(c + 1);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted summary.
    // Predict first so a same-edge summary could never overtake its request.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_req_t  req;
        col_summary_t exp_s;
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (cfg_write)
                quiet_cycles = 0;
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                req = requests_open.pop_front();
                summarise_sample(req.smp, req.typed, req.want);
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (summaries_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected summary column=%0d channel=%0d", $time,
                             column, channel);
                end
                else
                begin
                    exp_s = summaries_due.pop_front();
                    if (column !== exp_s.column)
                    begin
                        errors++;
                        $display("%0t: column expected %0d actual %0d", $time,
                                 exp_s.column, column);
                    end
                    if (channel !== exp_s.channel)
                    begin
                        errors++;
                        $display("%0t: channel expected %0d actual %0d", $time,
                                 exp_s.channel, channel);
                    end
                    if (minimum !== exp_s.minimum)
                    begin
                        errors++;
                        $display("%0t: minimum expected %0d actual %0d", $time,
                                 exp_s.minimum, minimum);
                    end
                    if (maximum !== exp_s.maximum)
                    begin
                        errors++;
                        $display("%0t: maximum expected %0d actual %0d", $time,
                                 exp_s.maximum, maximum);
                    end
                    if (root_mean_square !== exp_s.rms)
                    begin
                        errors++;
                        $display("%0t: rms expected %0d actual %0d", $time,
                                 exp_s.rms, root_mean_square);
                    end
                    if (truncated !== exp_s.truncated)
                    begin
                        errors++;
                        $display("%0t: truncated expected %0b actual %0b", $time,
                                 exp_s.truncated, truncated);
                    end
                    if (last !== exp_s.last)
                    begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b", $time,
                                 exp_s.last, last);
                    end
                end
            end
            // Watchdog: nothing moved for far too long.
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off when asked so the block
    // backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. All called at a falling edge and return at one.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [15:0] smp, input logic typed,
                               input col_summary_t want);
        sample_req_t req;
        if (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req.smp   = smp;
        req.typed = typed;
        req.want  = want;
        requests_open.push_back(req);
        in_valid <= 1'b1;
        sample   <= smp;
        // Hold the request until the block takes it.
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait for every summary, then let stray samples drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (requests_open.size() != 0 || summaries_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [24:0] val);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_register(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'(signed'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. Typed rows run under view 1 / column 1 / channel 1, so
    // every sample is its own column: min = max = sample, rms = |sample|.
    // ------------------------------------------------------------------------
    stim_row_t rows [0:30];

    initial
    begin
        col_summary_t want;
        int           n_cfg;
        rows[0]  = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh7FFF, 1'b1, 16'd32767};
        rows[1]  = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh8000, 1'b1, 16'd32768};
        rows[2]  = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh0000, 1'b1, 16'd0};
        rows[3]  = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh0001, 1'b1, 16'd1};
        rows[4]  = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'shFFFF, 1'b1, 16'd1};
        rows[5]  = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh5555, 1'b1, 16'd21845};
        // Zero in every register must act as one.
        rows[6]  = '{ROW_WRITE, REG_VIEW_LENGTH, 25'd0, 16'sh0, 1'b0, 16'd0};
        rows[7]  = '{ROW_WRITE, REG_COLUMN_COUNT, 25'd0, 16'sh0, 1'b0, 16'd0};
        rows[8]  = '{ROW_WRITE, REG_CHANNEL_COUNT, 25'd0, 16'sh0, 1'b0, 16'd0};
        rows[9]  = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'shAAAA, 1'b1, 16'd21846};
        // The spare slot is ignored and must not restart the view.
        rows[10] = '{ROW_WRITE, REG_SPARE, 25'h1FFFFFF, 16'sh0, 1'b0, 16'd0};
        // One frame over the full width: 4096 columns close, 64 go out.
        rows[11] = '{ROW_WRITE, REG_COLUMN_COUNT, 25'd4096, 16'sh0, 1'b0, 16'd0};
        rows[12] = '{ROW_WRITE, REG_CHANNEL_COUNT, 25'd2, 16'sh0, 1'b0, 16'd0};
        rows[13] = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh1234, 1'b0, 16'd0};
        rows[14] = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'shEDCB, 1'b0, 16'd0};
        // Width above the cap acts as the cap.
        rows[15] = '{ROW_WRITE, REG_COLUMN_COUNT, 25'h1FFF, 16'sh0, 1'b0, 16'd0};
        rows[16] = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh7FFF, 1'b0, 16'd0};
        // Channel count above the cap acts as eight; two columns per frame.
        rows[17] = '{ROW_WRITE, REG_COLUMN_COUNT, 25'd2, 16'sh0, 1'b0, 16'd0};
        rows[18] = '{ROW_WRITE, REG_CHANNEL_COUNT, 25'd15, 16'sh0, 1'b0, 16'd0};
        for (int i = 0; i < 8; i++)
            rows[19 + i] = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'(i * 9000 - 32768),
                             1'b0, 16'd0};
        // Longest view: samples close nothing.
        rows[27] = '{ROW_WRITE, REG_VIEW_LENGTH, 25'h1FFFFFF, 16'sh0, 1'b0, 16'd0};
        rows[28] = '{ROW_WRITE, REG_CHANNEL_COUNT, 25'd1, 16'sh0, 1'b0, 16'd0};
        rows[29] = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh8000, 1'b0, 16'd0};
        rows[30] = '{ROW_SAMPLE, REG_SPARE, 25'd0, 16'sh7FFF, 1'b0, 16'd0};

        errors       = 0;
        quiet_cycles = 0;
        idle_en      = 1'b1;
        hold_off     = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_VIEW_LENGTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample       = '0;
        view_len_q   = 25'd1;
        col_cnt_q    = 13'd1;
        chan_cnt_q   = 4'd1;
        restart_view();

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the table.
        foreach (rows[r])
        begin
            if (rows[r].kind == ROW_WRITE)
                write_register(rows[r].index, rows[r].data);
            else
            begin
                want.column    = '0;
                want.channel   = '0;
                want.minimum   = rows[r].smp;
                want.maximum   = rows[r].smp;
                want.rms       = rows[r].rms;
                want.truncated = 1'b0;
                want.last      = 1'b1;
                send_sample(rows[r].smp, rows[r].typed, want);
            end
        end

        // Random phases over small views so columns close often. Phase 2 is
        // the wide-width case, phase 3 backs the block up under a long
        // receiver hold-off, phase 4 runs without any idling.
        want = '0;
        for (int p = 0; p < 6; p++)
        begin
            n_cfg = $urandom_range(0, 2);
            if (p == 3)
            begin
                write_register(REG_VIEW_LENGTH, 25'd1);
                write_register(REG_COLUMN_COUNT, 25'd1);
                write_register(REG_CHANNEL_COUNT, 25'd1);
                hold_off = 1'b1;
            end
            else
            begin
                write_register(REG_VIEW_LENGTH, 25'($urandom_range(1, 16)));
                write_register(REG_COLUMN_COUNT,
                               25'($urandom_range(1, (p == 2) ? 140 : 24)));
                write_register(REG_CHANNEL_COUNT, 25'($urandom_range(1, 8)));
                // Sometimes rewrite one register again mid-setting.
                if (n_cfg == 0)
                    write_register(REG_CHANNEL_COUNT, 25'($urandom_range(1, 4)));
            end
            idle_en = (p != 4);
            repeat (40) send_sample(pick_sample(), 1'b0, want);
        end
        idle_en = 1'b1;

        settle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
